// ===== rtl/lzc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the LoG zero-crossing edge marker.
// No dependencies; every other file imports this package.
package lzc_pkg;

	localparam int GRAD_W       = 15;
	localparam int THR_W        = 16;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int ROW_W        = 12;
	localparam int PADDR_W      = 4;
	localparam int EDGE_W       = 8;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_CNT_W   = 3;

	localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT   = 13'd4096;
	localparam logic [HEIGHT_REG_W-1:0] MIN_HEIGHT   = 13'd3;
	localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd512;
	localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd512;
	localparam logic [EDGE_W-1:0]       EDGE_ON      = 8'd255;
	localparam logic [EDGE_W-1:0]       EDGE_OFF     = 8'd0;

	// Register indexes, byte address = 4 * index
	localparam logic [1:0] REG_WIDTH      = 2'd0;
	localparam logic [1:0] REG_HEIGHT     = 2'd1;
	localparam logic [1:0] REG_CROSS_THR  = 2'd2;
	localparam logic [1:0] REG_GRAD_THR   = 2'd3;

	typedef struct packed {
		logic [EDGE_W-1:0] edge_value;
		logic              row_end;
		logic              frame_end;
	} result_t;

endpackage

// ===== rtl/lzc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input and marker output.
// Depends on lzc_pkg.
interface lzc_in_if import lzc_pkg::*; #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] log_sample;
	logic [GRAD_W-1:0]             grad_sample;

	modport source (output valid, output log_sample, output grad_sample, input ready);
	modport sink (input valid, input log_sample, input grad_sample, output ready);
endinterface

interface lzc_out_if import lzc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [EDGE_W-1:0] edge_value;
	logic              row_end;
	logic              frame_end;

	modport source (output valid, output edge_value, output row_end, output frame_end,
		input ready);
	modport sink (input valid, input edge_value, input row_end, input frame_end,
		output ready);
endinterface

// ===== rtl/log_zero_crossing_edge_marker.sv =====
`timescale 1ns / 1ps
// LoG zero-crossing edge marker, top level.
// Depends on lzc_pkg, lzc_if, lzc_line_store and lzc_out_fifo.
//
// Usage:
//   pixel  : valid/ready sink, one beat per pixel in raster order, carrying the
//            Q12.4 LoG sample and the Q11.4 gradient magnitude.
//   marker : valid/ready source, one beat per interior pixel: edge_value is 255
//            or 0, row_end marks the last interior pixel of a row, frame_end the
//            last one of the frame. Border pixels give no beat.
//   APB    : four registers at byte addresses 0, 4, 8, 12 (width, height,
//            crossing threshold, gradient threshold); write only while idle.
// Throughput: one pixel per clock while pixel.ready is high. The line buffers
// live in one memory read at acceptance and written back on the next cycle.
// The marker for centre (r-1,c-1) passes stage 1 and stage 2 after pixel (r,c)
// is accepted, and is then pushed into the output queue.
// Reset clears the counters, the 3x3 window and the queue; line memory content is
// not cleared, and the first two rows of a frame only fill it.
// When the receiver stalls, up to four marker beats queue up; pixel.ready drops
// only once beats in flight plus queued beats reach four.
module log_zero_crossing_edge_marker import lzc_pkg::*; #(
	parameter int MAX_WIDTH   = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	lzc_in_if.sink             pixel,
	lzc_out_if.source          marker,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam int CNT_W   = $clog2(MAX_WIDTH);
	localparam int WCMP_W  = (CNT_W + 1 > WIDTH_REG_W) ? CNT_W + 1 : WIDTH_REG_W;
	localparam int DW      = (SAMPLE_BITS + 1 > THR_W) ? SAMPLE_BITS + 1 : THR_W;

	// Configuration registers
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [THR_W-1:0]        cross_thr_q;
	logic [GRAD_W-1:0]       grad_thr_q;

	// Stream control
	logic [CNT_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [WCMP_W-1:0]       w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;
	logic                    accept;
	logic                    col_last;
	logic                    row_last;
	logic                    produce;

	logic                    v_s1, prod_s1, rend_s1, fend_s1;
	logic                    v_s2, prod_s2, rend_s2, fend_s2;

	logic signed [SAMPLE_BITS-1:0] win_q [9];
	logic [GRAD_W-1:0]             gd_q [2];
	logic signed [SAMPLE_BITS-1:0] top, mid;
	logic [GRAD_W-1:0]             gmid;
	logic signed [SAMPLE_BITS-1:0] bot_s1;

	logic                  any_cross;
	result_t               res;
	logic [FIFO_CNT_W-1:0] q_count;
	logic [FIFO_CNT_W-1:0] occupancy;

	function automatic logic crosses(input logic signed [SAMPLE_BITS-1:0] a,
		input logic signed [SAMPLE_BITS-1:0] b, input logic [THR_W-1:0] thr);
		logic                  a_neg, a_pos, b_neg, b_pos;
		logic [SAMPLE_BITS:0]  d;
		logic [SAMPLE_BITS:0]  ad;
		a_neg = a[SAMPLE_BITS-1];
		a_pos = !a[SAMPLE_BITS-1] && (a != '0);
		b_neg = b[SAMPLE_BITS-1];
		b_pos = !b[SAMPLE_BITS-1] && (b != '0);
		d     = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
		ad    = d[SAMPLE_BITS] ? (~d + (SAMPLE_BITS+1)'(1)) : d;
		return ((a_neg && b_pos) || (a_pos && b_neg)) && (DW'(ad) > DW'(thr));
	endfunction

	// ---------------- configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= RESET_WIDTH;
			height_q    <= RESET_HEIGHT;
			cross_thr_q <= '0;
			grad_thr_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_WIDTH:     width_q     <= pwdata[WIDTH_REG_W-1:0];
				REG_HEIGHT:    height_q    <= pwdata[HEIGHT_REG_W-1:0];
				REG_CROSS_THR: cross_thr_q <= pwdata[THR_W-1:0];
				REG_GRAD_THR:  grad_thr_q  <= pwdata[GRAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:     prdata = 32'(width_q);
			REG_HEIGHT:    prdata = 32'(height_q);
			REG_CROSS_THR: prdata = 32'(cross_thr_q);
			REG_GRAD_THR:  prdata = 32'(grad_thr_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------- stage 0: counters, memory read
	always_comb begin
		if (WCMP_W'(width_q) < WCMP_W'(3)) begin
			w_eff = WCMP_W'(3);
		end else if (WCMP_W'(width_q) > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WCMP_W'(MAX_WIDTH);
		end else begin
			w_eff = WCMP_W'(width_q);
		end
		if (height_q < MIN_HEIGHT) begin
			h_eff = MIN_HEIGHT;
		end else if (height_q > MAX_HEIGHT) begin
			h_eff = MAX_HEIGHT;
		end else begin
			h_eff = height_q;
		end
	end

	assign col_last = (WCMP_W'(col_q) + WCMP_W'(1)) >= w_eff;
	assign row_last = (HEIGHT_REG_W'(row_q) + HEIGHT_REG_W'(1)) >= h_eff;
	assign produce  = (row_q >= ROW_W'(2)) && (col_q >= CNT_W'(2));

	// Hold off input once in-flight plus queued beats could fill the queue
	assign occupancy   = q_count + FIFO_CNT_W'(v_s1) + FIFO_CNT_W'(v_s2);
	assign pixel.ready = occupancy < FIFO_CNT_W'(FIFO_DEPTH);
	assign accept      = pixel.valid & pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	lzc_line_store #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.bot     (pixel.log_sample),
		.grad    (pixel.grad_sample),
		.top     (top),
		.mid     (mid),
		.gmid    (gmid)
	);

	// ---------------- stage 1: window shift; stage 2: evaluate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= produce;
			rend_s1 <= col_last;
			fend_s1 <= col_last && row_last;
		end
		if (v_s1) begin
			prod_s2 <= prod_s1;
			rend_s2 <= rend_s1;
			fend_s2 <= fend_s1;
		end
	end

	// Bottom sample of the window comes from bot_s1, registered here at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			gd_q[0] <= '0;
			gd_q[1] <= '0;
		end else if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]     <= win_q[k*3 + 1];
				win_q[k*3 + 1] <= win_q[k*3 + 2];
			end
			win_q[2] <= top;
			win_q[5] <= mid;
			win_q[8] <= bot_s1;
			gd_q[0]  <= gd_q[1];
			gd_q[1]  <= gmid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bot_s1 <= pixel.log_sample;
		end
	end

	// Pairs: N/S, NE/SW, E/W, SE/NW
	assign any_cross = crosses(win_q[1], win_q[7], cross_thr_q)
		|| crosses(win_q[2], win_q[6], cross_thr_q)
		|| crosses(win_q[5], win_q[3], cross_thr_q)
		|| crosses(win_q[8], win_q[0], cross_thr_q);

	always_comb begin
		res.edge_value = ((gd_q[0] > grad_thr_q) && any_cross) ? EDGE_ON : EDGE_OFF;
		res.row_end    = rend_s2;
		res.frame_end  = fend_s2;
	end

	lzc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2 & prod_s2),
		.push_data (res),
		.count     (q_count),
		.marker    (marker)
	);

endmodule

// ===== rtl/lzc_line_store.sv =====
`timescale 1ns / 1ps
// Line store: one synchronous memory holding, per column, the two older LoG rows
// and the previous magnitude row; read, then written back in the next cycle. Uses lzc_pkg.
module lzc_line_store import lzc_pkg::*; #(
	parameter int MAX_WIDTH   = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  logic signed [SAMPLE_BITS-1:0] bot,
	input  logic [GRAD_W-1:0]             grad,
	output logic signed [SAMPLE_BITS-1:0] top,
	output logic signed [SAMPLE_BITS-1:0] mid,
	output logic [GRAD_W-1:0]             gmid
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int EW = 2 * SAMPLE_BITS + GRAD_W;

	logic [EW-1:0]          mem [MAX_WIDTH];
	logic [EW-1:0]          rd_q;
	logic                   wen_s1;
	logic [AW-1:0]          waddr_s1;
	logic [SAMPLE_BITS-1:0] bot_s1;
	logic [GRAD_W-1:0]      grad_s1;

	// Entry layout: older row | newer row | magnitude
	assign top  = rd_q[EW-1 -: SAMPLE_BITS];
	assign mid  = rd_q[GRAD_W +: SAMPLE_BITS];
	assign gmid = rd_q[GRAD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wen_s1 <= 1'b0;
		end else begin
			wen_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			waddr_s1 <= rd_addr;
			bot_s1   <= bot;
			grad_s1  <= grad;
		end
	end

	// Write back lands in the cycle after the read of the same column. The next read
	// is always for another column (width is at least 3), so no forwarding.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (wen_s1) begin
			mem[waddr_s1] <= {rd_q[GRAD_W +: SAMPLE_BITS], bot_s1, grad_s1};
		end
	end

endmodule

// ===== rtl/lzc_out_fifo.sv =====
`timescale 1ns / 1ps
// Output queue of marker beats; decouples the pipeline from receiver stalls.
// Depends on lzc_pkg and lzc_out_if.
module lzc_out_fifo import lzc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  result_t               push_data,
	output logic [FIFO_CNT_W-1:0] count,
	lzc_out_if.source             marker
);
	localparam int PW = $clog2(FIFO_DEPTH);

	result_t               mem_q [FIFO_DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign marker.valid      = (cnt_q != '0);
	assign marker.edge_value = mem_q[rd_ptr_q].edge_value;
	assign marker.row_end    = mem_q[rd_ptr_q].row_end;
	assign marker.frame_end  = mem_q[rd_ptr_q].frame_end;
	assign pop               = marker.valid & marker.ready;
	assign count             = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
